@@ design/se2_pkg.sv @@
// Shared constants and types for the SE(2) edge error and Jacobian unit.
package se2_pkg;

  localparam int ATAN_COUNT = 24;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [16:0] PI_Q12 = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [33:0] cq_t;

  function automatic cq_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sh03243F6A8;
      1: atan_q30 = 34'sh01DAC6705;
      2: atan_q30 = 34'sh00FADBAFC;
      3: atan_q30 = 34'sh007F56EA6;
      4: atan_q30 = 34'sh003FEAB76;
      5: atan_q30 = 34'sh001FFD55B;
      6: atan_q30 = 34'sh000FFFAAA;
      7: atan_q30 = 34'sh0007FFF55;
      8: atan_q30 = 34'sh0003FFFEA;
      9: atan_q30 = 34'sh0001FFFFD;
      10: atan_q30 = 34'sh0000FFFFF;
      11: atan_q30 = 34'sh00007FFFF;
      12: atan_q30 = 34'sh00003FFFF;
      13: atan_q30 = 34'sh00001FFFF;
      14: atan_q30 = 34'sh00000FFFF;
      15: atan_q30 = 34'sh000007FFF;
      16: atan_q30 = 34'sh000003FFF;
      17: atan_q30 = 34'sh000001FFF;
      18: atan_q30 = 34'sh000000FFF;
      19: atan_q30 = 34'sh0000007FF;
      20: atan_q30 = 34'sh0000003FF;
      21: atan_q30 = 34'sh0000001FF;
      22: atan_q30 = 34'sh0000000FF;
      23: atan_q30 = 34'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -51'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ design/se2_cordic.sv @@
// Unrolled rotation-mode CORDIC pipeline: one iteration per register stage.
module se2_cordic
  import se2_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [14:0] heading,
  output logic signed [15:0] cos_q14,
  output logic signed [15:0] sin_q14
);

  cq_t x_r [STAGES+1];
  cq_t y_r [STAGES+1];
  cq_t z_r [STAGES+1];
  logic flip_r [STAGES+1];
  cq_t z0;

  always_comb begin
    z0 = cq_t'(heading) <<< 18;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      if (z0 > HALF_PI_Q30) begin
        z_r[0] <= z0 - PI_Q30;
        flip_r[0] <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_r[0] <= z0 + PI_Q30;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  logic signed [17:0] cr, sr, cc, sc;

  always_comb begin
    cr = 18'((x_r[STAGES] + 34'sd32768) >>> 16);
    sr = 18'((y_r[STAGES] + 34'sd32768) >>> 16);
    cc = (cr > 18'sd16384) ? 18'sd16384 : ((cr < -18'sd16384) ? -18'sd16384 : cr);
    sc = (sr > 18'sd16384) ? 18'sd16384 : ((sr < -18'sd16384) ? -18'sd16384 : sr);
    cos_q14 = flip_r[STAGES] ? -cc[15:0] : cc[15:0];
    sin_q14 = flip_r[STAGES] ? -sc[15:0] : sc[15:0];
  end

endmodule

@@ design/se2_edge_error_and_jacobian_unit.sv @@
// Top level of the SE(2) edge error and Jacobian unit.
// Pipeline: input fold register, CORDIC stages, then product, sum and output registers.
// Throughput: one transaction per cycle while the output is not stalled; the unrolled CORDIC sets the depth.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Synchronous active-low reset clears the valid bits only; no other state.
module se2_edge_error_and_jacobian_unit
  import se2_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_from_x,
  input  logic signed [31:0] in_from_y,
  input  logic signed [14:0] in_from_heading,
  input  logic signed [31:0] in_to_x,
  input  logic signed [31:0] in_to_y,
  input  logic signed [14:0] in_to_heading,
  input  logic signed [31:0] in_meas_x,
  input  logic signed [31:0] in_meas_y,
  input  logic signed [14:0] in_meas_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [14:0] out_res_heading,
  output logic signed [15:0] out_cos_heading,
  output logic signed [15:0] out_sin_heading,
  output logic signed [31:0] out_jac_from_x_heading,
  output logic signed [31:0] out_jac_from_y_heading
);

  localparam int DEPTH = CORDIC_STAGES + 1;
  localparam int STG = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [14:0] eh;
  } side_t;

  logic en;
  logic [DEPTH+2:0] vld_r;
  side_t side_r [DEPTH];
  side_t side_in;
  logic signed [16:0] eh_raw;
  logic signed [16:0] eh_w;
  logic signed [15:0] c_w, s_w;

  // global stall: the output register is full and not drained
  assign en = !(vld_r[DEPTH+2] && out_stall);
  assign in_stall = !en;

  always_comb begin
    eh_raw = 17'(in_to_heading) - 17'(in_from_heading) - 17'(in_meas_heading);
    eh_w = eh_raw;
    // error stays within about +/- 3.8*pi (49151 in Q12), so two wrap steps suffice
    if (eh_w > PI_Q12) eh_w = eh_w - TWO_PI_Q12;
    if (eh_w > PI_Q12) eh_w = eh_w - TWO_PI_Q12;
    if (eh_w < -PI_Q12) eh_w = eh_w + TWO_PI_Q12;
    if (eh_w < -PI_Q12) eh_w = eh_w + TWO_PI_Q12;
    side_in.dx = 33'(in_to_x) - 33'(in_from_x);
    side_in.dy = 33'(in_to_y) - 33'(in_from_y);
    side_in.mx = in_meas_x;
    side_in.my = in_meas_y;
    side_in.eh = eh_w[14:0];
  end

  se2_cordic #(.STAGES(STG)) u_cordic (
    .clk     (clk),
    .en      (en),
    .heading (in_from_heading),
    .cos_q14 (c_w),
    .sin_q14 (s_w)
  );

  // side data runs alongside the CORDIC
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < DEPTH; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH+1:0], in_valid};
    end
  end

  // product stage
  logic signed [48:0] cdx_r, sdy_r, cdy_r, sdx_r;
  logic signed [15:0] c_r, s_r, c2_r, s2_r;
  side_t p_r, q_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cdx_r <= 49'(c_w) * 49'(side_r[DEPTH-1].dx);
      sdy_r <= 49'(s_w) * 49'(side_r[DEPTH-1].dy);
      cdy_r <= 49'(c_w) * 49'(side_r[DEPTH-1].dy);
      sdx_r <= 49'(s_w) * 49'(side_r[DEPTH-1].dx);
      c_r <= c_w;
      s_r <= s_w;
      p_r <= side_r[DEPTH-1];
    end
  end

  // sum and round stage
  logic signed [50:0] lx_r, ly_r, jy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      lx_r <= (51'(cdx_r) + 51'(sdy_r) + 51'sd8192) >>> 14;
      ly_r <= (51'(cdy_r) - 51'(sdx_r) + 51'sd8192) >>> 14;
      jy_r <= (-51'(cdx_r) - 51'(sdy_r) + 51'sd8192) >>> 14;
      c2_r <= c_r;
      s2_r <= s_r;
      q_r <= p_r;
    end
  end

  // subtract, saturate, output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_res_x <= sat32(lx_r - 51'(q_r.mx));
      out_res_y <= sat32(ly_r - 51'(q_r.my));
      out_res_heading <= q_r.eh;
      out_cos_heading <= c2_r;
      out_sin_heading <= s2_r;
      out_jac_from_x_heading <= sat32(ly_r);
      out_jac_from_y_heading <= sat32(jy_r);
    end
  end

  assign out_valid = vld_r[DEPTH+2];

  logic unused_frac;
  assign unused_frac = (POS_FRAC_BITS > 0);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_x))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cos_heading <= ONE_Q14 && out_cos_heading >= -ONE_Q14)
    else $error("cosine out of range");
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 17'(out_res_heading) <= PI_Q12 && 17'(out_res_heading) >= -PI_Q12)
    else $error("heading error not wrapped");

endmodule

@@ tb/sv/se2_edge_error_and_jacobian_unit_tb.sv @@
// Self-checking testbench for the SE(2) edge error and Jacobian unit.
`timescale 1ns / 100ps

module se2_edge_error_and_jacobian_unit_tb
  import se2_pkg::*;
;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 4;
  localparam int N_RANDOM = 1800;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] fx, fy;
    logic signed [14:0] fh;
    logic signed [31:0] tx, ty;
    logic signed [14:0] th;
    logic signed [31:0] mx, my;
    logic signed [14:0] mh;
  } edge_t;

  typedef struct packed {
    logic signed [31:0] rx, ry;
    logic signed [14:0] rh;
    logic signed [15:0] c, s;
    logic signed [31:0] jx, jy;
  } resid_t;

  // Predicts residuals and Jacobian terms, holds them in arrival order.
  class edge_scoreboard;
    resid_t pending[$];
    int errors;
    int checked;

    function longint fshift(longint v, int sh);
      return v >>> sh;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint round_q14(longint v);
      longint r;
      r = fshift(v + 32768, 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
    endfunction

    function resid_t predict(edge_t e);
      resid_t r;
      longint z, x, y, nx, c, s, dx, dy, lx, ly, jx, jy, eh;
      bit flip;
      z = longint'(e.fh) * 262144;
      flip = 0;
      x = GAIN_Q30;
      y = 0;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30; flip = 1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30; flip = 1;
      end
      for (int i = 0; i < STAGES && i < ATAN_COUNT; i++) begin
        if (z >= 0) begin
          nx = x - fshift(y, i); y = y + fshift(x, i); z -= longint'(atan_q30(i));
        end else begin
          nx = x + fshift(y, i); y = y - fshift(x, i); z += longint'(atan_q30(i));
        end
        x = nx;
      end
      c = round_q14(x);
      s = round_q14(y);
      if (flip) begin
        c = -c; s = -s;
      end
      dx = longint'(e.tx) - longint'(e.fx);
      dy = longint'(e.ty) - longint'(e.fy);
      lx = fshift(c * dx + s * dy + 8192, 14);
      ly = fshift(c * dy - s * dx + 8192, 14);
      jy = fshift(-(c * dx) - s * dy + 8192, 14);
      jx = ly;
      eh = longint'(e.th) - longint'(e.fh) - longint'(e.mh);
      while (eh > 12868) eh -= 25736;
      while (eh < -12868) eh += 25736;
      r.rx = 32'(clamp32(lx - longint'(e.mx)));
      r.ry = 32'(clamp32(ly - longint'(e.my)));
      r.rh = eh[14:0];
      r.c = c[15:0];
      r.s = s[15:0];
      r.jx = 32'(clamp32(jx));
      r.jy = 32'(clamp32(jy));
      return r;
    endfunction

    function void note_edge(edge_t e);
      pending.push_back(predict(e));
    endfunction

    function void cmp(string name, longint exp, longint act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(resid_t a);
      resid_t x;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      cmp("res_x", x.rx, a.rx);
      cmp("res_y", x.ry, a.ry);
      cmp("res_heading", x.rh, a.rh);
      cmp("cos_heading", x.c, a.c);
      cmp("sin_heading", x.s, a.s);
      cmp("jac_from_x_heading", x.jx, a.jx);
      cmp("jac_from_y_heading", x.jy, a.jy);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_from_x = 0, in_from_y = 0, in_to_x = 0, in_to_y = 0;
  logic signed [31:0] in_meas_x = 0, in_meas_y = 0;
  logic signed [14:0] in_from_heading = 0, in_to_heading = 0, in_meas_heading = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_res_x, out_res_y, out_jac_from_x_heading, out_jac_from_y_heading;
  logic signed [14:0] out_res_heading;
  logic signed [15:0] out_cos_heading, out_sin_heading;

  edge_scoreboard sb = new();
  edge_t directed[$];
  longint cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  always #1 clk = ~clk;

  se2_edge_error_and_jacobian_unit #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_from_x(in_from_x), .in_from_y(in_from_y), .in_from_heading(in_from_heading),
    .in_to_x(in_to_x), .in_to_y(in_to_y), .in_to_heading(in_to_heading),
    .in_meas_x(in_meas_x), .in_meas_y(in_meas_y), .in_meas_heading(in_meas_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_x(out_res_x), .out_res_y(out_res_y), .out_res_heading(out_res_heading),
    .out_cos_heading(out_cos_heading), .out_sin_heading(out_sin_heading),
    .out_jac_from_x_heading(out_jac_from_x_heading),
    .out_jac_from_y_heading(out_jac_from_y_heading)
  );

  function automatic logic signed [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000000)) - 1000000;
      2: return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  function automatic logic signed [14:0] rand_ang();
    if ($urandom_range(0, 9) == 0) return 15'($urandom());  // full 15-bit range
    return 15'($signed($urandom_range(0, 25736)) - 12868);
  endfunction

  function automatic edge_t rand_edge();
    edge_t e;
    int m;
    m = $urandom_range(0, 9);
    m = (m < 4) ? 1 : (m < 7) ? 0 : (m < 8) ? 2 : 3;
    e.fx = rand_pos(m); e.fy = rand_pos(m);
    e.tx = rand_pos(m); e.ty = rand_pos(m);
    e.mx = rand_pos(m); e.my = rand_pos(m);
    e.fh = rand_ang(); e.th = rand_ang(); e.mh = rand_ang();
    return e;
  endfunction

  task automatic send_edge(edge_t e);
    in_valid <= 1;
    {in_from_x, in_from_y, in_from_heading, in_to_x, in_to_y, in_to_heading,
     in_meas_x, in_meas_y, in_meas_heading} <= e;
    do @(posedge clk); while (in_stall);
    sb.note_edge(e);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 6);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // Receiver: random stall pattern, plus one long hold-off.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1;
      else if (cycles % 512 < 128) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_res_x, out_res_y, out_res_heading, out_cos_heading,
                       out_sin_heading, out_jac_from_x_heading, out_jac_from_y_heading});
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    edge_t e;
    int hs[] = '{0, 1, -1, 12868, -12868, 6434, -6434, 6435, -6435, 16383, -16384, 3217};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (hs[i]) begin
      e = '0;
      e.fh = 15'(hs[i]); e.th = 15'(-hs[i]); e.mh = 15'(hs[i]);
      e.tx = 32'sh7FFFFFFF; e.fx = 32'sh80000000;
      e.ty = 32'sh80000000; e.fy = 32'sh7FFFFFFF;
      e.mx = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
      e.my = -e.mx - 1;
      directed.push_back(e);
    end
    for (int i = 0; i < 8; i++) begin
      e = '0;
      e.fh = (i % 2) ? 15'sh3FFF : 15'sh4000;
      e.th = (i % 2) ? 15'sh4000 : 15'sh3FFF;
      e.mh = (i < 4) ? 15'sh3FFF : 15'sh4000;
      e.tx = $signed(i * 65536); e.ty = -$signed(i * 32768);
      e.mx = 32'sh00010000; e.my = -1;
      directed.push_back(e);
    end
    foreach (directed[i]) send_edge(directed[i]);
    in_valid <= 0;
    // fill the pipeline against a stalled output
    hold_off = 1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 2 * LATENCY; i++) send_edge(rand_edge());
    join
    for (int n = 0; n < N_RANDOM; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) send_edge(rand_edge());
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    in_valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("checked %0d edge results: directed angle folds and extremes, saturation,",
             sb.checked);
    $display("random poses with bursty input, random output stalls and a full-pipe hold-off");
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
